/* src/hlb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlb_pkg
// Shared types, codes and constants of the handheld link bridge controller.
// ----------------------------------------------------------------------------
package hlb_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int FIFO_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FIFO_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam int LB_DEPTH    = 1024;
    localparam int LB_AW       = 10;

    localparam logic [2:0] REQ_LINE   = 3'd0;
    localparam logic [2:0] REQ_FRAME  = 3'd1;
    localparam logic [2:0] REQ_PIXEL  = 3'd2;
    localparam logic [2:0] REQ_JOYPAD = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_WRITE  = 3'd5;

    localparam logic [22:0] READ_MASK  = 23'h40ffff;
    localparam logic [22:0] CMD_MASK   = 23'h40fff0;
    localparam logic [22:0] RA_LINE    = 23'h006000;
    localparam logic [22:0] RA_CMDRDY  = 23'h006002;
    localparam logic [22:0] RA_REV     = 23'h00600f;
    localparam logic [22:0] RA_CMD     = 23'h007000;
    localparam logic [22:0] RA_VRAM    = 23'h007800;
    localparam logic [15:0] WA_BANK    = 16'h6001;
    localparam logic [15:0] WA_CTRL    = 16'h6003;
    localparam logic [15:0] WA_PAD_LO  = 16'h6004;
    localparam logic [15:0] WA_PAD_HI  = 16'h6007;
    localparam logic [7:0]  REVISION   = 8'h21;
    localparam logic [7:0]  PIX_LIMIT  = 8'd160;

    typedef logic [15:0][7:0] t_bytes16;
    typedef logic [3:0][7:0]  t_pads;

    typedef struct packed {
        logic       lk_joyp;
        logic       lk_pulse;
        logic       lk_strobe;
        logic       lk_packet;
        logic [1:0] pad_index;
        logic [3:0] byte_index;
        logic [2:0] bit_index;
        logic [7:0] shift_byte;
    } t_joy_state;

    typedef struct packed {
        t_joy_state state;
        logic [3:0] nibble;
        logic       asm_we;
        logic [3:0] asm_idx;
        logic [7:0] asm_byte;
        logic       push;
    } t_joy_res;

    localparam t_joy_state JOY_RESET = '{lk_joyp: 1'b1, lk_pulse: 1'b1, lk_strobe: 1'b0,
                                         lk_packet: 1'b0, pad_index: 2'd0,
                                         byte_index: 4'd0, bit_index: 3'd0,
                                         shift_byte: 8'd0};

endpackage

/* src/hlb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlb_ram
// Simple dual-port synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/hlb_joypad.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlb_joypad
// Joypad select decoder: pad multiplexing, returned nibble and the
// pulse/bit-coded command packet deserializer.
// ----------------------------------------------------------------------------
module hlb_joypad import hlb_pkg::*; (
    input  t_joy_state  i_state,
    input  t_pads       i_pads,
    input  logic [1:0]  i_player_mode,
    input  logic        i_p14,
    input  logic        i_p15,
    output t_joy_res    o_res
);

    always_comb begin
        t_joy_state s;
        logic [7:0] pad;
        logic [3:0] nib;
        logic       done;
        s    = i_state;
        done = 1'b0;
        o_res.asm_we   = 1'b0;
        o_res.asm_idx  = i_state.byte_index;
        o_res.asm_byte = 8'd0;
        o_res.push     = 1'b0;

        if (i_p14 && i_p15 && !s.lk_joyp) begin
            s.lk_joyp = 1'b1;
            s.pad_index = s.pad_index + 2'd1;
            if (i_player_mode == 2'd0) begin
                s.pad_index = 2'd0;
            end else if (i_player_mode == 2'd1) begin
                s.pad_index[1] = 1'b0;
            end
        end
        pad = i_pads[s.pad_index];
        nib = 4'hf;
        if (i_p14 && i_p15) begin
            nib = 4'hf - {2'd0, s.pad_index};
        end
        if (!i_p14) begin
            nib = nib & pad[3:0];
        end
        if (!i_p15) begin
            nib = nib & pad[7:4];
        end
        if (i_p14 && !i_p15) begin
            s.lk_joyp = !s.lk_joyp;
        end

        if (!i_p14 && !i_p15) begin
            s.lk_pulse   = 1'b0;
            s.byte_index = 4'd0;
            s.bit_index  = 3'd0;
            s.lk_strobe  = 1'b1;
            s.lk_packet  = 1'b0;
            done = 1'b1;
        end else if (s.lk_pulse) begin
            done = 1'b1;
        end else if (i_p14 && i_p15) begin
            s.lk_strobe = 1'b0;
            done = 1'b1;
        end

        if (!done) begin
            if (s.lk_strobe) begin
                s.lk_packet  = 1'b0;
                s.lk_pulse   = 1'b1;
                s.bit_index  = 3'd0;
                s.byte_index = 4'd0;
            end
            s.lk_strobe = 1'b1;
            if (s.lk_packet) begin
                if (!i_p14 && i_p15) begin
                    o_res.push  = 1'b1;
                    s.lk_packet = 1'b0;
                    s.lk_pulse  = 1'b1;
                end
            end else begin
                s.shift_byte = {!i_p15, s.shift_byte[7:1]};
                s.bit_index  = s.bit_index + 3'd1;
                if (s.bit_index == 3'd0) begin
                    o_res.asm_we   = 1'b1;
                    o_res.asm_idx  = s.byte_index;
                    o_res.asm_byte = s.shift_byte;
                    s.byte_index   = s.byte_index + 4'd1;
                    if (s.byte_index == 4'd0) begin
                        s.lk_packet = 1'b1;
                    end
                end
            end
        end

        o_res.state  = s;
        o_res.nibble = nib;
    end

endmodule

/* src/handheld_link_bridge_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_link_bridge_controller
// Bridge between an emulated handheld and a host bus: line buffer, joypad
// multiplexer, command packet FIFO and host register file.
// ----------------------------------------------------------------------------
// The line buffer and packet FIFO are read as a beat is accepted; the result,
// including any write back, is formed from the registered beat, which stalls
// while the output is held, and no new beat is taken until it moves on. Each
// 16-bit line buffer word holds eight pixels of both bitplanes, so a pixel is
// one read-modify-write. After reset and after a soft reset the line buffer is
// filled with 0xff in a pass over its 1024 words; no beat is taken meanwhile.
module handheld_link_bridge_controller import hlb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [1:0]  i_pixel_color,
    input  logic        i_select_p14,
    input  logic        i_select_p15,
    input  logic [22:0] i_bus_addr,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic [3:0]  o_joyp_nibble,
    output logic        o_handheld_reset,
    output logic        o_handheld_run,
    output logic [1:0]  o_clock_div_sel
);

    logic               r_s1_valid;
    logic [2:0]         r_s1_type;
    logic [1:0]         r_s1_color;
    logic               r_s1_p14;
    logic               r_s1_p15;
    logic [22:0]        r_s1_addr;
    logic [7:0]         r_s1_data;
    logic [LB_AW-1:0]   r_s1_lbaddr;

    logic               r_clr_busy;
    logic [LB_AW-1:0]   r_clr_addr;

    logic [7:0]         r_line_count, n_line_count;
    logic [1:0]         r_write_bank, n_write_bank;
    logic [7:0]         r_column,     n_column;
    logic [1:0]         r_read_bank,  n_read_bank;
    logic [8:0]         r_read_ptr,   n_read_ptr;
    logic [7:0]         r_ctrl,       n_ctrl;
    t_pads              r_pads,       n_pads;
    t_bytes16           r_cmd,        n_cmd;
    t_bytes16           r_asm,        n_asm;
    t_joy_state         r_joy,        n_joy;
    logic [FIFO_AW-1:0] r_fifo_head,  n_fifo_head;
    logic [FIFO_CW-1:0] r_fifo_count, n_fifo_count;
    logic               n_clr;

    logic               r_out_valid;
    logic [7:0]         r_out_rd;
    logic [3:0]         r_out_nib;
    logic               r_out_rst;
    logic [7:0]         r_out_ctrl;

    logic               in_accept;
    logic               s1_fire;
    logic [LB_AW-1:0]   lb_raddr;
    logic [LB_AW-1:0]   lb_pix_addr;
    logic [15:0]        lb_rdata;
    logic               lb_we;
    logic [LB_AW-1:0]   lb_waddr;
    logic [15:0]        lb_wdata;
    logic               pix_we;
    logic [15:0]        pix_wdata;
    logic [127:0]       fifo_rdata;
    logic               fifo_we;
    logic [FIFO_AW-1:0] fifo_slot;
    logic [FIFO_CW:0]   slot_sum;
    logic [7:0]         s_rd;
    logic [3:0]         s_nib;
    logic               s_rst;
    t_joy_res           joy_res;

    assign o_ready   = !r_s1_valid && !r_clr_busy;
    assign in_accept = i_valid && o_ready;
    assign s1_fire   = r_s1_valid && (!r_out_valid || i_ready);

    assign lb_pix_addr = {r_write_bank, r_column[7:3], r_line_count[2:0]};
    assign lb_raddr    = (i_req_type == REQ_PIXEL) ? lb_pix_addr
                                                   : {r_read_bank, r_read_ptr[8:1]};

    assign lb_we    = r_clr_busy || pix_we;
    assign lb_waddr = r_clr_busy ? r_clr_addr : r_s1_lbaddr;
    assign lb_wdata = r_clr_busy ? 16'hffff : pix_wdata;

    assign slot_sum  = {1'b0, {(FIFO_CW - FIFO_AW){1'b0}}, r_fifo_head}
                     + {1'b0, r_fifo_count};
    assign fifo_slot = (slot_sum >= (FIFO_CW + 1)'(QUEUE_DEPTH))
                     ? FIFO_AW'(slot_sum - (FIFO_CW + 1)'(QUEUE_DEPTH))
                     : FIFO_AW'(slot_sum);

    hlb_ram #(.WIDTH(16), .DEPTH(LB_DEPTH)) u_line_buffer (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (lb_wdata),
        .i_re    (in_accept),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    hlb_ram #(.WIDTH(128), .DEPTH(QUEUE_DEPTH)) u_packet_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_slot),
        .i_wdata (r_asm),
        .i_re    (in_accept),
        .i_raddr (r_fifo_head),
        .o_rdata (fifo_rdata)
    );

    hlb_joypad u_joypad (
        .i_state       (r_joy),
        .i_pads        (r_pads),
        .i_player_mode (r_ctrl[5:4]),
        .i_p14         (r_s1_p14),
        .i_p15         (r_s1_p15),
        .o_res         (joy_res)
    );

    always_comb begin
        logic [22:0] ra;
        logic [15:0] wa;
        ra = r_s1_addr & READ_MASK;
        wa = r_s1_addr[15:0];
        n_line_count = r_line_count;
        n_write_bank = r_write_bank;
        n_column     = r_column;
        n_read_bank  = r_read_bank;
        n_read_ptr   = r_read_ptr;
        n_ctrl       = r_ctrl;
        n_pads       = r_pads;
        n_cmd        = r_cmd;
        n_asm        = r_asm;
        n_joy        = r_joy;
        n_fifo_head  = r_fifo_head;
        n_fifo_count = r_fifo_count;
        n_clr        = 1'b0;
        s_rd         = 8'd0;
        s_nib        = 4'd0;
        s_rst        = 1'b0;
        pix_we       = 1'b0;
        pix_wdata    = {lb_rdata[14:8], r_s1_color[1], lb_rdata[6:0], r_s1_color[0]};
        fifo_we      = 1'b0;

        case (r_s1_type)
            REQ_LINE: begin
                n_column     = 8'd0;
                n_line_count = r_line_count + 8'd1;
                if (n_line_count[2:0] == 3'd0) begin
                    n_write_bank = r_write_bank + 2'd1;
                end
            end
            REQ_FRAME: begin
                n_column     = 8'd0;
                n_line_count = 8'd0;
            end
            REQ_PIXEL: begin
                n_column = r_column + 8'd1;
                if (r_column < PIX_LIMIT) begin
                    pix_we = s1_fire;
                end
            end
            REQ_JOYPAD: begin
                n_joy = joy_res.state;
                s_nib = joy_res.nibble;
                if (joy_res.asm_we) begin
                    n_asm[joy_res.asm_idx] = joy_res.asm_byte;
                end
                if (joy_res.push && (r_fifo_count < FIFO_CW'(QUEUE_DEPTH))) begin
                    fifo_we      = s1_fire;
                    n_fifo_count = r_fifo_count + FIFO_CW'(1);
                end
            end
            REQ_READ: begin
                if (ra == RA_LINE) begin
                    s_rd = {r_line_count[7:3], 1'b0, r_write_bank};
                end else if (ra == RA_CMDRDY) begin
                    if (r_fifo_count != '0) begin
                        n_cmd        = fifo_rdata;
                        n_fifo_head  = (r_fifo_head == FIFO_AW'(QUEUE_DEPTH - 1))
                                     ? '0 : r_fifo_head + FIFO_AW'(1);
                        n_fifo_count = r_fifo_count - FIFO_CW'(1);
                        s_rd         = 8'd1;
                    end
                end else if (ra == RA_REV) begin
                    s_rd = REVISION;
                end else if ((ra & CMD_MASK) == RA_CMD) begin
                    s_rd = r_cmd[ra[3:0]];
                end else if (ra == RA_VRAM) begin
                    s_rd       = r_read_ptr[0] ? lb_rdata[15:8] : lb_rdata[7:0];
                    n_read_ptr = r_read_ptr + 9'd1;
                end
            end
            REQ_WRITE: begin
                if (wa == WA_BANK) begin
                    n_read_bank = r_s1_data[1:0];
                    n_read_ptr  = 9'd0;
                end else if (wa == WA_CTRL) begin
                    if (!r_ctrl[7] && r_s1_data[7]) begin
                        n_line_count = 8'd0;
                        n_write_bank = 2'd0;
                        n_column     = 8'd0;
                        n_read_bank  = 2'd0;
                        n_read_ptr   = 9'd0;
                        n_pads       = '1;
                        n_cmd        = '0;
                        n_asm        = '0;
                        n_joy        = JOY_RESET;
                        n_fifo_head  = '0;
                        n_fifo_count = '0;
                        n_clr        = 1'b1;
                        s_rst        = 1'b1;
                    end
                    if (r_s1_data[5:4] == 2'd1) begin
                        n_joy.pad_index[1] = 1'b0;
                    end else if (r_s1_data[5]) begin
                        n_joy.pad_index = 2'd0;
                    end
                    n_ctrl = r_s1_data;
                end else if (wa inside {[WA_PAD_LO:WA_PAD_HI]}) begin
                    n_pads[wa[1:0]] = r_s1_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_line_count <= 8'd0;
            r_write_bank <= 2'd0;
            r_column     <= 8'd0;
            r_read_bank  <= 2'd0;
            r_read_ptr   <= 9'd0;
            r_ctrl       <= 8'd0;
            r_pads       <= '1;
            r_cmd        <= '0;
            r_asm        <= '0;
            r_joy        <= JOY_RESET;
            r_fifo_head  <= '0;
            r_fifo_count <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid  <= 1'b1;
                r_line_count <= n_line_count;
                r_write_bank <= n_write_bank;
                r_column     <= n_column;
                r_read_bank  <= n_read_bank;
                r_read_ptr   <= n_read_ptr;
                r_ctrl       <= n_ctrl;
                r_pads       <= n_pads;
                r_cmd        <= n_cmd;
                r_asm        <= n_asm;
                r_joy        <= n_joy;
                r_fifo_head  <= n_fifo_head;
                r_fifo_count <= n_fifo_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire && n_clr) begin
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + LB_AW'(1);
                if (r_clr_addr == LB_AW'(LB_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_type   <= i_req_type;
            r_s1_color  <= i_pixel_color;
            r_s1_p14    <= i_select_p14;
            r_s1_p15    <= i_select_p15;
            r_s1_addr   <= i_bus_addr;
            r_s1_data   <= i_write_data;
            r_s1_lbaddr <= lb_pix_addr;
        end
        if (s1_fire) begin
            r_out_rd   <= s_rd;
            r_out_nib  <= s_nib;
            r_out_rst  <= s_rst;
            r_out_ctrl <= n_ctrl;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_out_rd;
    assign o_joyp_nibble    = r_out_nib;
    assign o_handheld_reset = r_out_rst;
    assign o_handheld_run   = r_out_ctrl[7];
    assign o_clock_div_sel  = r_out_ctrl[1:0];

endmodule

/* sim/handheld_link_bridge_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_link_bridge_controller_tb
// Self-checking bench: drives handheld events and host bus beats, predicts
// every reply with a behavioral copy of the bridge and compares the replies
// in order, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module handheld_link_bridge_controller_tb;
    import hlb_pkg::*;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    typedef struct {
        logic [7:0] rd;
        logic [3:0] nib;
        logic       rst;
        logic       run;
        logic [1:0] div;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_req_type;
    logic [1:0]  i_pixel_color;
    logic        i_select_p14;
    logic        i_select_p15;
    logic [22:0] i_bus_addr;
    logic [7:0]  i_write_data;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_read_data;
    logic [3:0]  o_joyp_nibble;
    logic        o_handheld_reset;
    logic        o_handheld_run;
    logic [1:0]  o_clock_div_sel;

    handheld_link_bridge_controller u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Behavioral copy of the bridge state.
    logic [7:0] lbuf [2048];
    logic [7:0] pkt_ring [QUEUE_DEPTH][16];
    int         ring_head, ring_count;
    logic [7:0] asm_pkt [16];
    int         byte_idx, bit_idx;
    logic [7:0] shreg;
    bit         lk_joyp, lk_pulse, lk_strobe, lk_packet;
    int         pad_sel;
    logic [7:0] pads [4];
    logic [7:0] cmd_bytes [16];
    logic [7:0] ctrl;
    int         pmode, rbank, rptr, wbank, col, line;

    t_reply pending_replies[$];
    int     errors = 0;
    int     sent = 0;
    bit     no_idle = 1'b0;

    function automatic void bridge_clear();
        foreach (lbuf[i]) lbuf[i] = 8'hff;
        ring_head = 0;
        ring_count = 0;
        foreach (asm_pkt[i]) asm_pkt[i] = 8'h00;
        byte_idx = 0;
        bit_idx = 0;
        shreg = 8'h00;
        lk_joyp = 1'b1;
        lk_pulse = 1'b1;
        lk_strobe = 1'b0;
        lk_packet = 1'b0;
        pad_sel = 0;
        foreach (pads[i]) pads[i] = 8'hff;
        foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
        ctrl = 8'h00;
        pmode = 0;
        rbank = 0;
        rptr = 0;
        wbank = 0;
        col = 0;
        line = 0;
    endfunction

    function automatic logic [3:0] joypad_lines(bit p14, bit p15);
        logic [7:0] pad;
        logic [3:0] nib;
        bit         b;
        int         slot;
        if (p14 && p15 && !lk_joyp) begin
            lk_joyp = 1'b1;
            pad_sel = (pad_sel + 1) & 3;
            if (pmode == 0) pad_sel = 0;
            else if (pmode == 1) pad_sel &= 1;
        end
        pad = pads[pad_sel];
        nib = 4'hf;
        if (p14 && p15) nib = 4'hf - pad_sel[3:0];
        if (!p14) nib &= pad[3:0];
        if (!p15) nib &= pad[7:4];
        if (p14 && !p15) lk_joyp = !lk_joyp;
        if (!p14 && !p15) begin
            lk_pulse = 1'b0;
            byte_idx = 0;
            bit_idx = 0;
            lk_strobe = 1'b1;
            lk_packet = 1'b0;
            return nib;
        end
        if (lk_pulse) return nib;
        if (p14 && p15) begin
            lk_strobe = 1'b0;
            return nib;
        end
        if (lk_strobe) begin
            // A second single-line pulse without release: the packet is broken.
            lk_packet = 1'b0;
            lk_pulse = 1'b1;
            bit_idx = 0;
            byte_idx = 0;
        end
        b = !p15;
        lk_strobe = 1'b1;
        if (lk_packet) begin
            if (!p14 && p15) begin
                if (ring_count < QUEUE_DEPTH) begin
                    slot = (ring_head + ring_count) % QUEUE_DEPTH;
                    foreach (asm_pkt[i]) pkt_ring[slot][i] = asm_pkt[i];
                    ring_count++;
                end
                lk_packet = 1'b0;
                lk_pulse = 1'b1;
            end
            return nib;
        end
        shreg = {b, shreg[7:1]};
        bit_idx = (bit_idx + 1) & 7;
        if (bit_idx != 0) return nib;
        asm_pkt[byte_idx] = shreg;
        byte_idx = (byte_idx + 1) & 15;
        if (byte_idx != 0) return nib;
        lk_packet = 1'b1;
        return nib;
    endfunction

    function automatic logic [7:0] host_read_value(logic [22:0] addr);
        logic [22:0] a;
        logic [7:0]  v;
        a = addr & READ_MASK;
        if (a == RA_LINE) return 8'((line & 'hf8) | wbank);
        if (a == RA_CMDRDY) begin
            if (ring_count == 0) return 8'd0;
            foreach (cmd_bytes[i]) cmd_bytes[i] = pkt_ring[ring_head][i];
            ring_head = (ring_head + 1) % QUEUE_DEPTH;
            ring_count--;
            return 8'd1;
        end
        if (a == RA_REV) return REVISION;
        if ((a & CMD_MASK) == RA_CMD) return cmd_bytes[a[3:0]];
        if (a == RA_VRAM) begin
            v = lbuf[(rbank * 512 + rptr) & 'h7ff];
            rptr = (rptr + 1) & 'h1ff;
            return v;
        end
        return 8'd0;
    endfunction

    function automatic t_reply bridge_step(logic [2:0] kind, logic [1:0] color, bit p14,
                                           bit p15, logic [22:0] addr, logic [7:0] data);
        t_reply r;
        int     a, x;
        logic [15:0] wa;
        r = '{rd: 8'd0, nib: 4'd0, rst: 1'b0, run: 1'b0, div: 2'd0};
        case (kind)
            REQ_LINE: begin
                col = 0;
                line = (line + 1) & 'hff;
                if ((line & 7) == 0) wbank = (wbank + 1) & 3;
            end
            REQ_FRAME: begin
                col = 0;
                line = 0;
            end
            REQ_PIXEL: begin
                x = col;
                col = (col + 1) & 'hff;
                if (x < PIX_LIMIT) begin
                    a = (wbank * 512 + (line & 7) * 2 + (x / 8) * 16) & 'h7ff;
                    lbuf[a] = {lbuf[a][6:0], color[0]};
                    lbuf[(a + 1) & 'h7ff] = {lbuf[(a + 1) & 'h7ff][6:0], color[1]};
                end
            end
            REQ_JOYPAD: r.nib = joypad_lines(p14, p15);
            REQ_READ: r.rd = host_read_value(addr);
            REQ_WRITE: begin
                wa = addr[15:0];
                if (wa == WA_BANK) begin
                    rbank = data[1:0];
                    rptr = 0;
                end else if (wa == WA_CTRL) begin
                    if (!ctrl[7] && data[7]) begin
                        bridge_clear();
                        r.rst = 1'b1;
                    end
                    pmode = data[5:4];
                    if (pmode == 1) pad_sel &= 1;
                    else if (pmode >= 2) pad_sel = 0;
                    ctrl = data;
                end else if (wa >= WA_PAD_LO && wa <= WA_PAD_HI) begin
                    pads[wa[1:0]] = data;
                end
            end
            default: ;
        endcase
        r.run = ctrl[7];
        r.div = ctrl[1:0];
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge i_clk) begin
        t_reply w;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                report("unexpected reply", 0, 0);
            end else begin
                w = pending_replies.pop_front();
                if (o_read_data !== w.rd) report("read_data", o_read_data, w.rd);
                if (o_joyp_nibble !== w.nib) report("joyp_nibble", o_joyp_nibble, w.nib);
                if (o_handheld_reset !== w.rst)
                    report("handheld_reset", o_handheld_reset, w.rst);
                if (o_handheld_run !== w.run) report("handheld_run", o_handheld_run, w.run);
                if (o_clock_div_sel !== w.div)
                    report("clock_div_sel", o_clock_div_sel, w.div);
            end
        end
    end

    task automatic send_beat(logic [2:0] kind, logic [1:0] color, bit p14, bit p15,
                             logic [22:0] addr, logic [7:0] data);
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_pixel_color <= color;
        i_select_p14 <= p14;
        i_select_p15 <= p15;
        i_bus_addr <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_replies.push_back(bridge_step(kind, color, p14, p15, addr, data));
        sent++;
        if (!no_idle && $urandom_range(0, 99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic simple_beat(logic [2:0] kind);
        send_beat(kind, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic host_read(logic [22:0] addr);
        send_beat(REQ_READ, $urandom, $urandom, $urandom, addr, $urandom);
    endtask

    task automatic host_write(logic [22:0] addr, logic [7:0] data);
        send_beat(REQ_WRITE, $urandom, $urandom, $urandom, addr, data);
    endtask

    task automatic select_lines(bit p14, bit p15);
        send_beat(REQ_JOYPAD, $urandom, p14, p15, $urandom, $urandom);
    endtask

    // Reset pulse, 128 data bits LSB first, then the stop pulse. A short packet
    // stops after cut bits and ends with a double single-line pulse instead.
    task automatic send_packet(int cut);
        logic [127:0] payload;
        bit           b;
        payload = {$urandom, $urandom, $urandom, $urandom};
        select_lines(1'b0, 1'b0);
        select_lines(1'b1, 1'b1);
        for (int i = 0; i < 128 && i < cut; i++) begin
            b = payload[i];
            select_lines(b, !b);
            select_lines(1'b1, 1'b1);
        end
        if (cut < 128) select_lines(1'b1, 1'b0);
        select_lines(1'b0, 1'b1);
        select_lines(1'b1, 1'b1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [22:0] pick_read_addr();
        logic [22:0] a;
        case ($urandom_range(0, 5))
            0: a = RA_LINE;
            1: a = RA_CMDRDY;
            2: a = RA_REV;
            3: a = RA_CMD | 23'($urandom_range(0, 15));
            4: a = RA_VRAM;
            default: a = 23'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) a |= 23'($urandom) & 23'h7f0000;
        return a;
    endfunction

    function automatic logic [22:0] pick_write_addr();
        logic [22:0] a;
        case ($urandom_range(0, 3))
            0: a = 23'(WA_BANK);
            1: a = 23'(WA_CTRL);
            2: a = 23'($urandom_range(WA_PAD_LO, WA_PAD_HI));
            default: a = 23'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) a |= 23'($urandom) & 23'h7f0000;
        return a;
    endfunction

    task automatic test_directed();
        simple_beat(REQ_SPARE_A);
        simple_beat(REQ_SPARE_B);
        host_read(23'h000000);
        host_read(23'h7fffff);
        host_read(RA_REV);
        host_read(RA_REV | 23'h400000);
        host_read(RA_REV | 23'h3f0000);
        host_read(RA_CMDRDY);
        host_read(RA_LINE);
        host_write(WA_CTRL | 23'h7f0000, 8'hb3);
        host_write(WA_CTRL, 8'hff);
        host_write(WA_CTRL, 8'h00);
        host_write(23'h7fffff, 8'hff);
        host_write(WA_PAD_LO, 8'h00);
        send_beat(REQ_PIXEL, 2'd3, 1'b1, 1'b1, 23'h7fffff, 8'hff);
        send_beat(REQ_PIXEL, 2'd0, 1'b0, 1'b0, 23'h0, 8'h0);
        simple_beat(REQ_LINE);
        simple_beat(REQ_FRAME);
        host_read(RA_VRAM);
        select_lines(1'b0, 1'b0);
        select_lines(1'b1, 1'b1);
        select_lines(1'b0, 1'b1);
        select_lines(1'b1, 1'b0);
        host_read(RA_CMD | 23'h00000f);
    endtask

    task automatic test_line_buffer();
        for (int l = 0; l < 10; l++) begin
            simple_beat(REQ_LINE);
            for (int p = 0; p < ((l == 3) ? 270 : 6); p++) simple_beat(REQ_PIXEL);
        end
        host_read(RA_LINE);
        simple_beat(REQ_FRAME);
        for (int b = 0; b < 4; b++) begin
            host_write(WA_BANK, {6'($urandom_range(0, 63)), b[1:0]});
            for (int i = 0; i < 24; i++) host_read(RA_VRAM);
        end
    endtask

    task automatic test_joypad();
        for (int m = 0; m < 4; m++) begin
            for (int i = 0; i < 4; i++) host_write(23'(WA_PAD_LO) + 23'(i), $urandom);
            host_write(WA_CTRL, {2'b00, m[1:0], 2'b00, m[1:0]});
            repeat (12) select_lines($urandom, $urandom);
        end
    endtask

    task automatic test_packets();
        send_packet(128);
        send_packet(9);
        drain();
        host_read(RA_CMDRDY);
        for (int i = 0; i < 16; i++) host_read(RA_CMD | 23'(i));
        host_read(RA_CMDRDY);
        host_read(RA_CMD);
        host_read(RA_CMDRDY);
    endtask

    task automatic test_random();
        int r;
        int start;
        start = sent;
        no_idle = 1'b1;
        while (sent < 1100) begin
            if (sent - start >= 150) no_idle = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_packet($urandom_range(0, 12));
            end else begin
                if (r < 25) simple_beat(REQ_PIXEL);
                else if (r < 29) simple_beat(REQ_LINE);
                else if (r < 31) simple_beat(REQ_FRAME);
                else if (r < 50) select_lines($urandom, $urandom);
                else if (r < 72) host_read(pick_read_addr());
                else if (r < 88) host_write(pick_write_addr(),
                                            ($urandom_range(0, 3) == 0) ? $urandom : 8'h33);
                else if (r < 92) simple_beat($urandom_range(REQ_SPARE_A, REQ_SPARE_B));
                else simple_beat($urandom);
            end
        end
    endtask

    initial begin
        bridge_clear();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req_type <= REQ_LINE;
        i_pixel_color <= 2'd0;
        i_select_p14 <= 1'b1;
        i_select_p15 <= 1'b1;
        i_bus_addr <= '0;
        i_write_data <= '0;
        i_ready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_line_buffer();
        test_joypad();
        test_packets();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/hlb_pkg.sv
src/hlb_ram.sv
src/hlb_joypad.sv
src/handheld_link_bridge_controller.sv
sim/handheld_link_bridge_controller_tb.sv
